/* design/stripe_request_splitter_defines.svh */
// Assertion macros for the stripe request splitter.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef STRIPE_REQUEST_SPLITTER_DEFINES_SVH
`define STRIPE_REQUEST_SPLITTER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SRS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stripe_request_splitter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stripe_request_splitter: next-cycle check failed");

`else

`define SRS_ASSERT_SAME(label, ante, cons)
`define SRS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* design/srs_pkg.sv */
package srs_pkg;

  // Field widths fixed by the request and result formats.
  localparam int CHUNK_W     = 16;
  localparam int CHUNK_IDX_W = $clog2(CHUNK_W);
  localparam int MEMB_W      = 6;
  localparam int COUNT_W     = 7;
  localparam int MIDX_W      = 5;
  localparam int BOFF_W      = 15;
  localparam int BYTE_SHIFT  = 9;   // 512 bytes per sector

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SECTORS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEMBER_COUNT  = 2'd1;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 16'd128;
  localparam logic [MEMB_W-1:0]  MEMB_RESET  = 6'd2;

  // Result status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_CFG = 1'b1;

  typedef enum logic {
    OP_ADD,
    OP_SUB
  } srs_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_CHUNK,
    ST_DIV_MEMB,
    ST_MUL,
    ST_EMIT
  } srs_state_t;

endpackage

/* design/srs_addsub.sv */
module srs_addsub #(
  parameter int W = 48
) (
  input  logic [W-1:0]    a,
  input  logic [W-1:0]    b,
  input  srs_pkg::srs_op_t op,
  output logic [W-1:0]    sum,
  output logic            carry
);
  import srs_pkg::*;

  logic [W:0] full;
  logic [W-1:0] b_eff;

  // For a subtraction the carry out is set when a >= b.
  assign b_eff = (op == OP_SUB) ? ~b : b;
  assign full  = {1'b0, a} + {1'b0, b_eff} + (W+1)'(op == OP_SUB);
  assign sum   = full[W-1:0];
  assign carry = full[W];

endmodule

/* design/stripe_request_splitter.sv */
// Channel        Ports                                   Transfer
// -------------  --------------------------------------  ------------------------------------
// request in     start, busy, in_kind, in_start_sector,  start high while busy is low
//                in_sector_count
// piece out      out_valid, out_status ... out_last      out_valid high, no stall
// configuration  cfg_we, cfg_index, cfg_wdata             any edge with cfg_we high
//
// A request is set up by two restoring divisions of one bit per cycle and a shift-add
// multiply over the chunk size, all on the one shared adder, then hands out its pieces one
// after another; a request whose sectors wrap past the top of the address space repeats the
// setup once at the wrap. With an invalid configuration the single result is registered at
// the accepting edge and busy never rises. Each piece is shown for one cycle from the output
// registers. The reset is synchronous and restores the register defaults.
`include "stripe_request_splitter_defines.svh"

module stripe_request_splitter #(
  parameter int MAX_MEMBERS = 32,
  parameter int SECTOR_BITS = 48,
  parameter int MAX_COUNT   = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_kind,
  input  logic [SECTOR_BITS-1:0]             in_start_sector,
  input  logic [srs_pkg::COUNT_W-1:0]        in_sector_count,
  // Result channel
  output logic                               out_valid,
  output logic                               out_status,
  output logic                               out_is_write,
  output logic [srs_pkg::MIDX_W-1:0]         out_member_index,
  output logic [SECTOR_BITS-1:0]             out_member_sector,
  output logic [srs_pkg::COUNT_W-1:0]        out_run_sectors,
  output logic [srs_pkg::BOFF_W-1:0]         out_buffer_offset,
  output logic                               out_last,
  // Configuration port
  input  logic                               cfg_we,
  input  logic [srs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import srs_pkg::*;

  localparam int SB      = SECTOR_BITS;
  localparam int CW      = $clog2(SECTOR_BITS);
  localparam logic [CW-1:0] CNT_DIV = CW'(SECTOR_BITS - 1);
  localparam logic [CW-1:0] CNT_MUL = CW'(CHUNK_W - 1);

  // Configuration registers.
  logic [CHUNK_W-1:0] chunk_r;
  logic [MEMB_W-1:0]  members_r;

  // Sequencer and datapath registers.
  srs_state_t         state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [SB-1:0]      q_r, q_nxt;          // dividend in, quotient out
  logic [CHUNK_W-1:0] rem_r, rem_nxt;      // partial remainder
  logic [CHUNK_W-1:0] off_r, off_nxt;      // offset inside the current chunk
  logic [MEMB_W-1:0]  member_r, member_nxt;
  logic [SB-1:0]      base_r, base_nxt;    // member sector of the chunk start
  logic [SB-1:0]      lba_r, lba_nxt;      // array sector of the current piece
  logic [COUNT_W-1:0] left_r, left_nxt;    // sectors not yet handed out
  logic [COUNT_W-1:0] boff_r, boff_nxt;    // buffer offset in sectors
  logic               kind_r, kind_nxt;

  // Output registers.
  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r, out_status_nxt;
  logic               out_is_write_r, out_is_write_nxt;
  logic [MIDX_W-1:0]  out_member_index_r, out_member_index_nxt;
  logic [SB-1:0]      out_member_sector_r, out_member_sector_nxt;
  logic [COUNT_W-1:0] out_run_sectors_r, out_run_sectors_nxt;
  logic [BOFF_W-1:0]  out_buffer_offset_r, out_buffer_offset_nxt;
  logic               out_last_r, out_last_nxt;

  // Shared adder/subtractor.
  logic [SB-1:0] u_a, u_b, u_sum;
  logic          u_carry;
  srs_op_t       u_op;

  srs_addsub #(.W(SB)) u_addsub (
    .a     (u_a),
    .b     (u_b),
    .op    (u_op),
    .sum   (u_sum),
    .carry (u_carry)
  );

  // A configuration is unusable when either size is zero or there are too many members.
  logic bad_cfg;
  assign bad_cfg = (chunk_r == '0) || (members_r == '0) || (32'(members_r) > MAX_MEMBERS);

  logic [COUNT_W-1:0] count_sat;
  assign count_sat = (32'(in_sector_count) > MAX_COUNT) ? COUNT_W'(MAX_COUNT) : in_sector_count;

  // One restoring division step: the next dividend bit joins the partial remainder.
  logic [CHUNK_W-1:0] rem_step;
  assign rem_step = u_carry ? u_sum[CHUNK_W-1:0] : {rem_r[CHUNK_W-2:0], q_r[SB-1]};

  // Piece sizing. The piece ends at the chunk end or when the request runs out.
  logic [CHUNK_W-1:0] chunk_rem;
  logic [COUNT_W-1:0] run, left_after;
  logic [SB:0]        lba_adv;
  logic [MEMB_W-1:0]  member_inc;
  logic               member_wrap;
  logic [SB-1:0]      base_adv;

  assign chunk_rem   = chunk_r - off_r;
  assign run         = (chunk_rem > CHUNK_W'(left_r)) ? left_r : chunk_rem[COUNT_W-1:0];
  assign left_after  = left_r - run;
  assign lba_adv     = {1'b0, lba_r} + (SB+1)'(run);
  assign member_inc  = member_r + MEMB_W'(1);
  assign member_wrap = (member_inc == members_r);
  assign base_adv    = base_r + SB'(chunk_r);

  // Operand selection for the shared unit.
  always_comb begin
    u_a  = base_r;
    u_b  = SB'(off_r);
    u_op = OP_ADD;
    case (state_r)
      ST_DIV_CHUNK: begin
        u_a  = SB'({rem_r, q_r[SB-1]});
        u_b  = SB'(chunk_r);
        u_op = OP_SUB;
      end
      ST_DIV_MEMB: begin
        u_a  = SB'({rem_r, q_r[SB-1]});
        u_b  = SB'(members_r);
        u_op = OP_SUB;
      end
      ST_MUL: begin
        // Shift-add over the chunk size, most significant bit first.
        u_a  = {base_r[SB-2:0], 1'b0};
        u_b  = chunk_r[cnt_r[CHUNK_IDX_W-1:0]] ? q_r : '0;
        u_op = OP_ADD;
      end
      default: begin
        // In the piece state the unit forms base plus offset.
        u_a  = base_r;
        u_b  = SB'(off_r);
        u_op = OP_ADD;
      end
    endcase
  end

  // Next state and datapath updates.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    q_nxt      = q_r;
    rem_nxt    = rem_r;
    off_nxt    = off_r;
    member_nxt = member_r;
    base_nxt   = base_r;
    lba_nxt    = lba_r;
    left_nxt   = left_r;
    boff_nxt   = boff_r;
    kind_nxt   = kind_r;

    out_valid_nxt         = 1'b0;
    out_status_nxt        = out_status_r;
    out_is_write_nxt      = out_is_write_r;
    out_member_index_nxt  = out_member_index_r;
    out_member_sector_nxt = out_member_sector_r;
    out_run_sectors_nxt   = out_run_sectors_r;
    out_buffer_offset_nxt = out_buffer_offset_r;
    out_last_nxt          = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt = in_kind;
          if (bad_cfg) begin
            // A single error result, and the block stays idle.
            out_valid_nxt         = 1'b1;
            out_status_nxt        = STATUS_BAD_CFG;
            out_is_write_nxt      = in_kind;
            out_member_index_nxt  = '0;
            out_member_sector_nxt = '0;
            out_run_sectors_nxt   = '0;
            out_buffer_offset_nxt = '0;
            out_last_nxt          = 1'b1;
          end else begin
            lba_nxt   = in_start_sector;
            q_nxt     = in_start_sector;
            rem_nxt   = '0;
            cnt_nxt   = CNT_DIV;
            left_nxt  = count_sat;
            boff_nxt  = '0;
            state_nxt = ST_DIV_CHUNK;
          end
        end
      end
      ST_DIV_CHUNK: begin
        q_nxt   = {q_r[SB-2:0], u_carry};
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          // Quotient is the chunk index, remainder the offset in the chunk.
          off_nxt   = rem_step;
          rem_nxt   = '0;
          cnt_nxt   = CNT_DIV;
          state_nxt = ST_DIV_MEMB;
        end
      end
      ST_DIV_MEMB: begin
        q_nxt   = {q_r[SB-2:0], u_carry};
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          // Quotient is the stripe row, remainder the member number.
          member_nxt = rem_step[MEMB_W-1:0];
          base_nxt   = '0;
          cnt_nxt    = CNT_MUL;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        base_nxt = u_sum;
        cnt_nxt  = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_nxt         = 1'b1;
        out_status_nxt        = STATUS_OK;
        out_is_write_nxt      = kind_r;
        out_member_index_nxt  = member_r[MIDX_W-1:0];
        out_member_sector_nxt = u_sum;
        out_run_sectors_nxt   = run;
        out_buffer_offset_nxt = {boff_r[BOFF_W-BYTE_SHIFT-1:0], {BYTE_SHIFT{1'b0}}};
        out_last_nxt          = (left_after == '0);

        left_nxt = left_after;
        boff_nxt = boff_r + run;
        lba_nxt  = lba_adv[SB-1:0];
        if (left_after == '0) begin
          state_nxt = ST_IDLE;
        end else if (lba_adv[SB]) begin
          // The address wrapped past the top: map the new sector from scratch.
          q_nxt     = lba_adv[SB-1:0];
          rem_nxt   = '0;
          cnt_nxt   = CNT_DIV;
          state_nxt = ST_DIV_CHUNK;
        end else begin
          // Next piece starts at the following chunk, on the next member.
          off_nxt    = '0;
          member_nxt = member_wrap ? '0 : member_inc;
          base_nxt   = member_wrap ? base_adv : base_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      chunk_r     <= CHUNK_RESET;
      members_r   <= MEMB_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_CHUNK_SECTORS: chunk_r   <= cfg_wdata[CHUNK_W-1:0];
          REG_MEMBER_COUNT:  members_r <= cfg_wdata[MEMB_W-1:0];
          default: begin
            // Writes to unused indexes are dropped.
          end
        endcase
      end
    end
  end

  // Datapath and result payload.
  always_ff @(posedge clk) begin
    cnt_r               <= cnt_nxt;
    q_r                 <= q_nxt;
    rem_r               <= rem_nxt;
    off_r               <= off_nxt;
    member_r            <= member_nxt;
    base_r              <= base_nxt;
    lba_r               <= lba_nxt;
    left_r              <= left_nxt;
    boff_r              <= boff_nxt;
    kind_r              <= kind_nxt;
    out_status_r        <= out_status_nxt;
    out_is_write_r      <= out_is_write_nxt;
    out_member_index_r  <= out_member_index_nxt;
    out_member_sector_r <= out_member_sector_nxt;
    out_run_sectors_r   <= out_run_sectors_nxt;
    out_buffer_offset_r <= out_buffer_offset_nxt;
    out_last_r          <= out_last_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_is_write      = out_is_write_r;
  assign out_member_index  = out_member_index_r;
  assign out_member_sector = out_member_sector_r;
  assign out_run_sectors   = out_run_sectors_r;
  assign out_buffer_offset = out_buffer_offset_r;
  assign out_last          = out_last_r;

  // A piece that is not the last one leaves the sequencer still working on the request.
  `SRS_ASSERT_SAME(a_mid_piece_busy, out_valid && !out_last, busy)
  // A configuration error is always reported as the only, and so the last, transaction.
  `SRS_ASSERT_SAME(a_bad_cfg_last, out_valid && out_status == STATUS_BAD_CFG, out_last)
  // An accepted request either starts the sequencer or is answered at once with an error.
  `SRS_ASSERT_NEXT(a_start_taken, start && !busy,
                   busy || (out_valid && out_status == STATUS_BAD_CFG))

endmodule
